// File: rtl/core/rlr_pkg.sv
// rlr_pkg: shared types, widths and codes for the running line-fit core
`default_nettype none

package rlr_pkg;

    // width of the exact intermediate arithmetic (products, determinants)
    localparam int WIDE_W = 128;
    typedef logic [WIDE_W-1:0] wide_t;

    // limb size of the shared multiplier
    localparam int LIMB_W = 32;
    localparam int LIMBS  = WIDE_W / LIMB_W;
    localparam int LIMB_IDX_W = $clog2(LIMBS);

    // result field widths
    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;
    localparam int CORR_W  = 16;
    localparam int SERR_W  = 32;

    // square root result width and divider iteration counter width
    localparam int ROOT_W    = WIDE_W / 2;
    localparam int DIV_CNT_W = 8;

    // correlation is worked out as sqrt(2^30 * N^2 / (D*V))
    localparam int CORR_SHIFT = 30;

    // item commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_XX,
        ST_ACC_YY,
        ST_ACC_XY,
        ST_M_NSXX,
        ST_M_SXSX,
        ST_M_NSXY,
        ST_M_SXSY,
        ST_M_SYSXX,
        ST_M_SXSXY,
        ST_M_NSYY,
        ST_M_SYSY,
        ST_D_SLOPE,
        ST_D_ICPT,
        ST_M_NN,
        ST_M_DV,
        ST_D_CORR,
        ST_S_CORR,
        ST_M_NN2,
        ST_M_DEN,
        ST_D_STD,
        ST_S_STD,
        ST_DONE
    } rlr_state_t;

endpackage

`default_nettype wire

// File: rtl/core/rlr_mac.sv
// rlr_mac: 128-bit product modulo 2^128 built from 32x32 limb products
`default_nettype none

module rlr_mac
    import rlr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire wide_t op_a,
    input  wire wide_t op_b,
    output logic       done,
    output wide_t      product
);

    logic                  run_reg;
    logic [LIMB_IDX_W-1:0] ia_reg;
    logic [LIMB_IDX_W-1:0] ib_reg;
    logic [LIMB_IDX_W-1:0] sh_reg;
    logic                  pp_vld_reg;
    logic                  pp_last_reg;
    logic                  done_reg;
    logic [2*LIMB_W-1:0]   pp_reg;
    wide_t                 acc_reg;

    logic [LIMB_W-1:0]     a_limb;
    logic [LIMB_W-1:0]     b_limb;
    logic                  row_end;
    logic                  last_pair;

    // limb select: only pairs with ia + ib below LIMBS reach the low 128 bits
    always_comb
    begin
        a_limb    = op_a[ia_reg*LIMB_W +: LIMB_W];
        b_limb    = op_b[ib_reg*LIMB_W +: LIMB_W];
        row_end   = ((ia_reg + ib_reg) == LIMB_IDX_W'(LIMBS - 1));
        last_pair = (ia_reg == LIMB_IDX_W'(LIMBS - 1));
    end

    // pair walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg    <= pp_vld_reg && pp_last_reg;
            pp_vld_reg  <= run_reg;
            pp_last_reg <= run_reg && last_pair;
            if (start)
            begin
                run_reg <= 1'b1;
                ia_reg  <= '0;
                ib_reg  <= '0;
            end
            else if (run_reg)
            begin
                if (last_pair)
                begin
                    run_reg <= 1'b0;
                end
                if (row_end)
                begin
                    ia_reg <= ia_reg + 1'b1;
                    ib_reg <= '0;
                end
                else
                begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
        end
    end

    // limb product register, then shifted accumulate
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            pp_reg <= {{LIMB_W{1'b0}}, a_limb} * {{LIMB_W{1'b0}}, b_limb};
            sh_reg <= ia_reg + ib_reg;
        end
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + (WIDE_W'(pp_reg) << (sh_reg * LIMB_W));
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/rlr_div.sv
// rlr_div: restoring divider, floor(a * 2^s / b) kept modulo 2^128
`default_nettype none

module rlr_div
    import rlr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire wide_t                dividend,
    input  wire wide_t                divisor,
    input  wire logic [DIV_CNT_W-1:0] iters,
    output logic                      done,
    output wide_t                     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    wide_t                dvd_reg;
    wide_t                rem_reg;
    wide_t                q_reg;

    wide_t                rem_sh;
    logic                 ge;

    // one quotient bit per cycle; zeros shift in once the dividend runs out
    always_comb
    begin
        rem_sh = {rem_reg[WIDE_W-2:0], dvd_reg[WIDE_W-1]};
        ge     = (divisor != '0) && (rem_sh >= divisor);
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // shift-subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WIDE_W-2:0], 1'b0};
            rem_reg <= ge ? (rem_sh - divisor) : rem_sh;
            q_reg   <= {q_reg[WIDE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/rlr_sqrt.sv
// rlr_sqrt: digit-by-digit integer square root of a 128-bit value
`default_nettype none

module rlr_sqrt
    import rlr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire wide_t             radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    wide_t             rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[WIDE_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and root update
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[WIDE_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/running_linear_regression_core.sv
// running_linear_regression_core: running least-squares line fit over (x, y) points
//
// Each add item folds the point into the count and the sums of x, y, x*x, y*y and x*y
// (unless MAX_POINTS are held already) and, with three or more points, refits the line
// from those sums with exact integer arithmetic: one shared 32x32 limb multiplier (ten
// limb products per 128-bit product), one radix-2 divider (one quotient bit per cycle,
// 128 + shift bits) and one square root unit, all driven by a sequencer. Such a fit uses
// up to 15 products, four divisions and two roots; an add with fewer points uses only
// the three accumulation products, and clear and full items go straight to the result.
// in_stall is high while an item is worked on or its result waits for the output
// register; a finished result waits in the output register and the next item may be
// taken meanwhile. Slope and intercept carry FRAC_BITS fraction bits, correlation is
// |r| in Q1.15, std_error carries FRAC_BITS fraction bits; all saturate.
`default_nettype none

module running_linear_regression_core
    import rlr_pkg::*;
#(
    parameter int MAX_POINTS  = 65536,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic signed [SAMPLE_BITS-1:0] x_value,
    input  wire logic signed [SAMPLE_BITS-1:0] y_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [$clog2(MAX_POINTS+1)-1:0]    point_count,
    output logic                               ready_res,
    output logic                               fit_valid,
    output logic signed [SLOPE_W-1:0]          slope,
    output logic signed [ICPT_W-1:0]           intercept,
    output logic [CORR_W-1:0]                  correlation,
    output logic [SERR_W-1:0]                  std_error,
    output logic                               full_res
);

    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_RAW    = 2 * SAMPLE_BITS + CNT_W;
    localparam int SUM_W      = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int ITER_RATIO = WIDE_W + FRAC_BITS + 1;
    localparam int ITER_CORR  = WIDE_W + CORR_SHIFT;
    localparam int ITER_SERR  = WIDE_W + 2 * FRAC_BITS;
    localparam logic [CORR_W-1:0] CORR_MAX = CORR_W'(1 << (CORR_W - 1));

    // sequencer
    rlr_state_t state_reg, state_next;
    logic       started_reg;

    // sample point and running sums
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [SAMPLE_BITS-1:0] y_reg;
    logic [SUM_W-1:0]       sx_reg;
    logic [SUM_W-1:0]       sy_reg;
    logic [SUM_W-1:0]       sxx_reg;
    logic [SUM_W-1:0]       syy_reg;
    logic [SUM_W-1:0]       sxy_reg;

    // fit working registers
    wide_t t_reg;
    wide_t d_reg;
    wide_t n_reg;
    wide_t b_reg;
    wide_t v_reg;

    // item flags and held fit
    logic               fitv_reg;
    logic               full_reg;
    logic [SLOPE_W-1:0] slope_h_reg;
    logic [ICPT_W-1:0]  icpt_h_reg;
    logic [CORR_W-1:0]  corr_h_reg;
    logic [SERR_W-1:0]  serr_h_reg;

    // output register
    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_ready_reg;
    logic               out_fitv_reg;
    logic [SLOPE_W-1:0] out_slope_reg;
    logic [ICPT_W-1:0]  out_icpt_reg;
    logic [CORR_W-1:0]  out_corr_reg;
    logic [SERR_W-1:0]  out_serr_reg;
    logic               out_full_reg;

    // shared units
    logic                 mul_start, mul_done;
    wide_t                mul_a, mul_b, mul_p;
    logic                 div_start, div_done;
    wide_t                div_num, div_den, div_q;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 sqrt_start, sqrt_done;
    wide_t                sqrt_in;
    logic [ROOT_W-1:0]    sqrt_root;

    // handshake and derived values
    logic         in_accept;
    logic         out_take;
    logic         out_load;
    logic         is_full;
    wide_t        xs, ys, sxs, sys, sxxs, syys, sxys, n_w, nm2_w;
    wide_t        diff_tp;
    wide_t        r_new;
    logic         d_pos;
    logic         v_pos;
    logic [63:0]  slope_fix;
    logic [63:0]  icpt_fix;
    logic [SUM_W-1:0] x_ext, y_ext;

    // round half away from zero and saturate to w bits
    function automatic logic [63:0] ratio_fix(wide_t q, logic neg, int w);
        wide_t r1;
        wide_t lim;
        wide_t v;
        r1  = (q + WIDE_W'(1)) >> 1;
        lim = WIDE_W'(1) << (w - 1);
        if (!neg)
        begin
            lim = lim - WIDE_W'(1);
        end
        v = (r1 > lim) ? lim : r1;
        if (neg)
        begin
            v = -v;
        end
        return v[63:0];
    endfunction

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_DONE) && !(out_valid_reg && out_stall);
    assign is_full   = (cnt_reg >= CNT_W'(MAX_POINTS));

    // operand extension to the wide domain
    always_comb
    begin
        x_ext   = {{(SUM_W-SAMPLE_BITS){x_value[SAMPLE_BITS-1]}}, x_value};
        y_ext   = {{(SUM_W-SAMPLE_BITS){y_value[SAMPLE_BITS-1]}}, y_value};
        xs      = {{(WIDE_W-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
        ys      = {{(WIDE_W-SAMPLE_BITS){y_reg[SAMPLE_BITS-1]}}, y_reg};
        sxs     = {{(WIDE_W-SUM_W){sx_reg[SUM_W-1]}}, sx_reg};
        sys     = {{(WIDE_W-SUM_W){sy_reg[SUM_W-1]}}, sy_reg};
        sxxs    = {{(WIDE_W-SUM_W){sxx_reg[SUM_W-1]}}, sxx_reg};
        syys    = {{(WIDE_W-SUM_W){syy_reg[SUM_W-1]}}, syy_reg};
        sxys    = {{(WIDE_W-SUM_W){sxy_reg[SUM_W-1]}}, sxy_reg};
        n_w     = {{(WIDE_W-CNT_W){1'b0}}, cnt_reg};
        nm2_w   = {{(WIDE_W-CNT_W){1'b0}}, cnt_reg - CNT_W'(2)};
        diff_tp = t_reg - mul_p;
        r_new   = mul_p - n_reg;
        d_pos   = !diff_tp[WIDE_W-1] && (diff_tp != '0);
        v_pos   = !v_reg[WIDE_W-1] && (v_reg != '0);
        slope_fix = ratio_fix(div_q, n_reg[WIDE_W-1], SLOPE_W);
        icpt_fix  = ratio_fix(div_q, b_reg[WIDE_W-1], ICPT_W);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == CMD_CLEAR || is_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ACC_XX;
                    end
                end
            end
            ST_ACC_XX:  if (mul_done) state_next = ST_ACC_YY;
            ST_ACC_YY:  if (mul_done) state_next = ST_ACC_XY;
            ST_ACC_XY:
            begin
                if (mul_done)
                begin
                    state_next = (cnt_reg > CNT_W'(2)) ? ST_M_NSXX : ST_DONE;
                end
            end
            ST_M_NSXX:  if (mul_done) state_next = ST_M_SXSX;
            ST_M_SXSX:
            begin
                if (mul_done)
                begin
                    state_next = d_pos ? ST_M_NSXY : ST_DONE;
                end
            end
            ST_M_NSXY:  if (mul_done) state_next = ST_M_SXSY;
            ST_M_SXSY:  if (mul_done) state_next = ST_M_SYSXX;
            ST_M_SYSXX: if (mul_done) state_next = ST_M_SXSXY;
            ST_M_SXSXY: if (mul_done) state_next = ST_M_NSYY;
            ST_M_NSYY:  if (mul_done) state_next = ST_M_SYSY;
            ST_M_SYSY:  if (mul_done) state_next = ST_D_SLOPE;
            ST_D_SLOPE: if (div_done) state_next = ST_D_ICPT;
            ST_D_ICPT:  if (div_done) state_next = ST_M_NN;
            ST_M_NN:    if (mul_done) state_next = ST_M_DV;
            ST_M_DV:
            begin
                if (mul_done)
                begin
                    if (v_pos)
                    begin
                        state_next = ST_D_CORR;
                    end
                    else
                    begin
                        state_next = r_new[WIDE_W-1] ? ST_DONE : ST_M_NN2;
                    end
                end
            end
            ST_D_CORR:  if (div_done) state_next = ST_S_CORR;
            ST_S_CORR:
            begin
                if (sqrt_done)
                begin
                    state_next = v_reg[WIDE_W-1] ? ST_DONE : ST_M_NN2;
                end
            end
            ST_M_NN2:   if (mul_done) state_next = ST_M_DEN;
            ST_M_DEN:   if (mul_done) state_next = ST_D_STD;
            ST_D_STD:   if (div_done) state_next = ST_S_STD;
            ST_S_STD:   if (sqrt_done) state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb
    begin
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = n_w;
        mul_b      = sxxs;
        div_num    = n_reg;
        div_den    = d_reg;
        div_iters  = DIV_CNT_W'(ITER_RATIO);
        sqrt_in    = t_reg;
        case (state_reg)
            ST_ACC_XX:  begin mul_start = !started_reg; mul_a = xs;    mul_b = xs;    end
            ST_ACC_YY:  begin mul_start = !started_reg; mul_a = ys;    mul_b = ys;    end
            ST_ACC_XY:  begin mul_start = !started_reg; mul_a = xs;    mul_b = ys;    end
            ST_M_NSXX:  begin mul_start = !started_reg; mul_a = n_w;   mul_b = sxxs;  end
            ST_M_SXSX:  begin mul_start = !started_reg; mul_a = sxs;   mul_b = sxs;   end
            ST_M_NSXY:  begin mul_start = !started_reg; mul_a = n_w;   mul_b = sxys;  end
            ST_M_SXSY:  begin mul_start = !started_reg; mul_a = sxs;   mul_b = sys;   end
            ST_M_SYSXX: begin mul_start = !started_reg; mul_a = sys;   mul_b = sxxs;  end
            ST_M_SXSXY: begin mul_start = !started_reg; mul_a = sxs;   mul_b = sxys;  end
            ST_M_NSYY:  begin mul_start = !started_reg; mul_a = n_w;   mul_b = syys;  end
            ST_M_SYSY:  begin mul_start = !started_reg; mul_a = sys;   mul_b = sys;   end
            ST_M_NN:    begin mul_start = !started_reg; mul_a = n_reg; mul_b = n_reg; end
            ST_M_DV:    begin mul_start = !started_reg; mul_a = d_reg; mul_b = v_reg; end
            ST_M_NN2:   begin mul_start = !started_reg; mul_a = n_w;   mul_b = nm2_w; end
            ST_M_DEN:   begin mul_start = !started_reg; mul_a = t_reg; mul_b = d_reg; end
            ST_D_SLOPE:
            begin
                div_start = !started_reg;
                div_num   = n_reg[WIDE_W-1] ? -n_reg : n_reg;
            end
            ST_D_ICPT:
            begin
                div_start = !started_reg;
                div_num   = b_reg[WIDE_W-1] ? -b_reg : b_reg;
            end
            ST_D_CORR:
            begin
                div_start = !started_reg;
                div_num   = n_reg;
                div_den   = b_reg;
                div_iters = DIV_CNT_W'(ITER_CORR);
            end
            ST_D_STD:
            begin
                div_start = !started_reg;
                div_num   = v_reg;
                div_den   = d_reg;
                div_iters = DIV_CNT_W'(ITER_SERR);
            end
            ST_S_CORR:  sqrt_start = !started_reg;
            ST_S_STD:   sqrt_start = !started_reg;
            default:    ;
        endcase
    end

    // state and operation-issued flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                started_reg <= 1'b0;
            end
            else if (mul_start || div_start || sqrt_start)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    // count, sums, item flags and held fit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxx_reg     <= '0;
            syy_reg     <= '0;
            sxy_reg     <= '0;
            fitv_reg    <= 1'b0;
            full_reg    <= 1'b0;
            slope_h_reg <= '0;
            icpt_h_reg  <= '0;
            corr_h_reg  <= '0;
            serr_h_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                fitv_reg <= 1'b0;
                full_reg <= 1'b0;
                if (command == CMD_CLEAR)
                begin
                    cnt_reg <= '0;
                    sx_reg  <= '0;
                    sy_reg  <= '0;
                    sxx_reg <= '0;
                    syy_reg <= '0;
                    sxy_reg <= '0;
                end
                else if (is_full)
                begin
                    full_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sx_reg  <= sx_reg + x_ext;
                    sy_reg  <= sy_reg + y_ext;
                end
            end
            if (mul_done)
            begin
                case (state_reg)
                    ST_ACC_XX: sxx_reg <= sxx_reg + mul_p[SUM_W-1:0];
                    ST_ACC_YY: syy_reg <= syy_reg + mul_p[SUM_W-1:0];
                    ST_ACC_XY: sxy_reg <= sxy_reg + mul_p[SUM_W-1:0];
                    ST_M_SXSX:
                    begin
                        if (d_pos)
                        begin
                            fitv_reg <= 1'b1;
                        end
                        else
                        begin
                            slope_h_reg <= '0;
                            icpt_h_reg  <= '0;
                            corr_h_reg  <= '0;
                            serr_h_reg  <= '0;
                        end
                    end
                    ST_M_DV:
                    begin
                        corr_h_reg <= '0;
                        serr_h_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (div_done && state_reg == ST_D_SLOPE)
            begin
                slope_h_reg <= slope_fix[SLOPE_W-1:0];
            end
            if (div_done && state_reg == ST_D_ICPT)
            begin
                icpt_h_reg <= icpt_fix[ICPT_W-1:0];
            end
            if (sqrt_done && state_reg == ST_S_CORR)
            begin
                corr_h_reg <= (sqrt_root > ROOT_W'(CORR_MAX)) ? CORR_MAX
                                                               : sqrt_root[CORR_W-1:0];
            end
            if (sqrt_done && state_reg == ST_S_STD)
            begin
                serr_h_reg <= (sqrt_root > ROOT_W'({SERR_W{1'b1}})) ? {SERR_W{1'b1}}
                                                                     : sqrt_root[SERR_W-1:0];
            end
        end
    end

    // working registers for the fit
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= x_value;
            y_reg <= y_value;
        end
        if (mul_done)
        begin
            case (state_reg)
                ST_M_NSXX:  t_reg <= mul_p;
                ST_M_SXSX:  d_reg <= diff_tp;
                ST_M_NSXY:  t_reg <= mul_p;
                ST_M_SXSY:  n_reg <= diff_tp;
                ST_M_SYSXX: t_reg <= mul_p;
                ST_M_SXSXY: b_reg <= diff_tp;
                ST_M_NSYY:  t_reg <= mul_p;
                ST_M_SYSY:  v_reg <= diff_tp;
                ST_M_NN:    n_reg <= mul_p;
                ST_M_DV:
                begin
                    b_reg <= mul_p;
                    v_reg <= r_new;
                end
                ST_M_NN2:   t_reg <= mul_p;
                ST_M_DEN:   d_reg <= mul_p;
                default: ;
            endcase
        end
        if (div_done && (state_reg == ST_D_CORR || state_reg == ST_D_STD))
        begin
            t_reg <= div_q;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cnt_reg   <= cnt_reg;
            out_ready_reg <= (cnt_reg > CNT_W'(2));
            out_fitv_reg  <= fitv_reg;
            out_slope_reg <= slope_h_reg;
            out_icpt_reg  <= icpt_h_reg;
            out_corr_reg  <= corr_h_reg;
            out_serr_reg  <= serr_h_reg;
            out_full_reg  <= full_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_count = out_cnt_reg;
    assign ready_res   = out_ready_reg;
    assign fit_valid   = out_fitv_reg;
    assign slope       = out_slope_reg;
    assign intercept   = out_icpt_reg;
    assign correlation = out_corr_reg;
    assign std_error   = out_serr_reg;
    assign full_res    = out_full_reg;

    // shared multiplier
    rlr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // shared divider
    rlr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared square root
    rlr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

`ifndef SYNTHESIS
    // only one shared unit is launched at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_start, div_start, sqrt_start}))
        else $error("more than one unit started");

    // an accepted item always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

    // a computed fit needs at least three points
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!fit_valid || ready_res))
        else $error("fit reported with fewer than three points");

    // a dropped point never carries a fresh fit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(full_res && fit_valid))
        else $error("full item reported a fit");

    // correlation magnitude stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (correlation <= CORR_MAX))
        else $error("correlation above one");
`endif

endmodule

`default_nettype wire

// File: verif/line_fit_checker.sv
// line_fit_checker: watches both channels, predicts each fit result and compares it
`default_nettype none

module line_fit_checker
    import rlr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               command,
    input  wire logic signed [15:0] x_value,
    input  wire logic signed [15:0] y_value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [16:0]        point_count,
    input  wire logic               ready_res,
    input  wire logic               fit_valid,
    input  wire logic signed [31:0] slope,
    input  wire logic signed [47:0] intercept,
    input  wire logic [15:0]        correlation,
    input  wire logic [31:0]        std_error,
    input  wire logic               full_res,
    output int                      failures,
    output int                      pending_fits
);

    localparam int FRACTION = 16;
    localparam int POINT_LIMIT = 65536;

    typedef logic [127:0] u128;
    typedef logic [255:0] u256;

    typedef struct packed {
        logic [16:0] cnt;
        logic        rdy;
        logic        fv;
        logic [31:0] sl;
        logic [47:0] ic;
        logic [15:0] co;
        logic [31:0] se;
        logic        full;
    } fit_t;

    fit_t expected_fits[$];

    // running sums and held fit values, wrapping at 64 bits
    logic [16:0] n_pts;
    logic [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    logic [63:0] keep_slope, keep_icpt, keep_corr, keep_serr;

    // floor(a * 2^s / b) modulo 2^128, zero for a zero divisor
    function automatic u128 scaled_quotient(u128 a, int s, u128 b);
        u256 num;
        u256 quo;
        if (b == 0)
            return '0;
        num = {128'b0, a} << s;
        quo = num / {128'b0, b};
        return quo[127:0];
    endfunction

    // integer square root below 2^64
    function automatic logic [63:0] int_root(u128 a);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'b0, c} * {64'b0, c} <= a)
                r = c;
        end
        return r;
    endfunction

    // rounded ratio, ties away from zero, saturated to w bits
    function automatic logic [63:0] rounded_ratio(u128 num, u128 den, int w);
        logic neg;
        u128 a;
        u128 q;
        logic [63:0] lim;
        logic [63:0] v;
        neg = num[127];
        a = neg ? -num : num;
        q = scaled_quotient(a, FRACTION + 1, den);
        q = (q + 1) >> 1;
        lim = 64'd1 << (w - 1);
        if (!neg)
            lim = lim - 1;
        v = (q[127:64] != 0 || q[63:0] > lim) ? lim : q[63:0];
        if (neg)
            v = -v;
        return v;
    endfunction

    function automatic u128 widen(logic [63:0] s);
        return {{64{s[63]}}, s};
    endfunction

    // refit the line from the sums; returns 1 when the determinant is positive
    function automatic logic refit_line();
        u128 n, sx, sy, sxx, syy, sxy, det, num_s, num_i, var_y, n2, g, resid, den;
        logic [63:0] c;
        logic [63:0] e;
        n = {111'b0, n_pts};
        sx = widen(acc_x);
        sy = widen(acc_y);
        sxx = widen(acc_xx);
        syy = widen(acc_yy);
        sxy = widen(acc_xy);
        det = n * sxx - sx * sx;
        if (det[127] || det == 0)
        begin
            keep_slope = 0;
            keep_icpt = 0;
            keep_corr = 0;
            keep_serr = 0;
            return 1'b0;
        end
        num_s = n * sxy - sx * sy;
        num_i = sy * sxx - sx * sxy;
        var_y = n * syy - sy * sy;
        keep_slope = rounded_ratio(num_s, det, 32);
        keep_icpt = rounded_ratio(num_i, det, 48);
        n2 = num_s * num_s;
        g = det * var_y;
        c = 0;
        if (!var_y[127] && var_y != 0)
        begin
            c = int_root(scaled_quotient(n2, CORR_SHIFT, g));
            if (c > 32768)
                c = 32768;
        end
        keep_corr = c;
        resid = g - n2;
        e = 0;
        if (!resid[127])
        begin
            den = n * (n - 2) * det;
            e = int_root(scaled_quotient(resid, 2 * FRACTION, den));
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
        end
        keep_serr = e;
        return 1'b1;
    endfunction

    // fold one accepted item into the sums and queue its result
    function automatic void predict_item(logic cmd, logic signed [15:0] xv,
                                         logic signed [15:0] yv);
        fit_t f;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        f = '0;
        xs = xv;
        ys = yv;
        if (cmd == CMD_CLEAR)
        begin
            n_pts = '0;
            acc_x = 0;
            acc_y = 0;
            acc_xx = 0;
            acc_yy = 0;
            acc_xy = 0;
        end
        else if (n_pts >= POINT_LIMIT)
            f.full = 1'b1;
        else
        begin
            n_pts = n_pts + 17'd1;
            acc_x = acc_x + xs;
            acc_y = acc_y + ys;
            acc_xx = acc_xx + xs * xs;
            acc_yy = acc_yy + ys * ys;
            acc_xy = acc_xy + xs * ys;
            if (n_pts > 2)
                f.fv = refit_line();
        end
        f.cnt = n_pts;
        f.rdy = n_pts > 2;
        f.sl = keep_slope[31:0];
        f.ic = keep_icpt[47:0];
        f.co = keep_corr[15:0];
        f.se = keep_serr[31:0];
        expected_fits.push_back(f);
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_pts = '0;
            acc_x = '0;
            acc_y = '0;
            acc_xx = '0;
            acc_yy = '0;
            acc_xy = '0;
            keep_slope = '0;
            keep_icpt = '0;
            keep_corr = '0;
            keep_serr = '0;
            failures <= 0;
            pending_fits <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_fits.size() == 0)
                begin
                    $error("result with no item pending");
                    failures <= failures + 1;
                end
                else
                begin
                    fit_t e;
                    int bad;
                    e = expected_fits.pop_front();
                    bad = 0;
                    if (point_count !== e.cnt)
                    begin
                        $error("point_count exp %0d got %0d", e.cnt, point_count);
                        bad++;
                    end
                    if (ready_res !== e.rdy)
                    begin
                        $error("ready_res exp %0d got %0d", e.rdy, ready_res);
                        bad++;
                    end
                    if (fit_valid !== e.fv)
                    begin
                        $error("fit_valid exp %0d got %0d", e.fv, fit_valid);
                        bad++;
                    end
                    if (slope !== e.sl)
                    begin
                        $error("slope exp %h got %h", e.sl, slope);
                        bad++;
                    end
                    if (intercept !== e.ic)
                    begin
                        $error("intercept exp %h got %h", e.ic, intercept);
                        bad++;
                    end
                    if (correlation !== e.co)
                    begin
                        $error("correlation exp %0d got %0d", e.co, correlation);
                        bad++;
                    end
                    if (std_error !== e.se)
                    begin
                        $error("std_error exp %h got %h", e.se, std_error);
                        bad++;
                    end
                    if (full_res !== e.full)
                    begin
                        $error("full_res exp %0d got %0d", e.full, full_res);
                        bad++;
                    end
                    if (bad != 0)
                        failures <= failures + 1;
                end
            end
            if (in_valid && !in_stall)
                predict_item(command, x_value, y_value);
            pending_fits <= expected_fits.size();
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench: point stimulus, random idling and the verdict for the line-fit core
`default_nettype none

module testbench;
    import rlr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_ADD;
    logic signed [15:0] x_value = '0;
    logic signed [15:0] y_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [16:0]        point_count;
    logic               ready_res;
    logic               fit_valid;
    logic signed [31:0] slope;
    logic signed [47:0] intercept;
    logic [15:0]        correlation;
    logic [31:0]        std_error;
    logic               full_res;
    int                 failures;
    int                 pending_fits;

    logic calm = 1'b0;
    int   cycles = 0;
    int   hold = 0;
    int   adds = 0;
    int   clears = 0;

    always #4 clk = ~clk;

    running_linear_regression_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .x_value(x_value), .y_value(y_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_count(point_count), .ready_res(ready_res), .fit_valid(fit_valid),
        .slope(slope), .intercept(intercept), .correlation(correlation),
        .std_error(std_error), .full_res(full_res)
    );

    line_fit_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .x_value(x_value), .y_value(y_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_count(point_count), .ready_res(ready_res), .fit_valid(fit_valid),
        .slope(slope), .intercept(intercept), .correlation(correlation),
        .std_error(std_error), .full_res(full_res),
        .failures(failures), .pending_fits(pending_fits)
    );

    // receiver stall, redrawn after each accepted result
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            hold = calm ? 0 : $urandom_range(0, 19);
            out_stall <= hold > 0;
        end
        else if (hold > 0)
        begin
            hold = hold - 1;
            out_stall <= hold > 0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(logic cmd, logic signed [15:0] xv, logic signed [15:0] yv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command <= cmd;
        x_value <= xv;
        y_value <= yv;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_CLEAR)
            clears++;
        else
            adds++;
    endtask

    task automatic add_point(int xv, int yv);
        send_item(CMD_ADD, 16'(xv), 16'(yv));
    endtask

    initial
    begin
        int kind;
        int base_x;
        int base_y;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, too few points, then a fit
        add_point(-32768, -32768);
        add_point(32767, 32767);
        add_point(0, 0);
        add_point(-32768, 32767);
        // clear ignores the sample fields
        send_item(CMD_CLEAR, 16'h7fff, 16'h8000);
        // vertical line: zero determinant
        add_point(5, 1);
        add_point(5, -9);
        add_point(5, 300);
        // flat line: zero y variance
        send_item(CMD_CLEAR, '0, '0);
        add_point(-7, 42);
        add_point(100, 42);
        add_point(2000, 42);
        // steep slope that saturates
        send_item(CMD_CLEAR, '0, '0);
        add_point(32766, -32768);
        add_point(32767, 32767);
        add_point(32766, -32768);
        add_point(32767, 32767);
        // perfect line, zero residual
        send_item(CMD_CLEAR, '0, '0);
        add_point(1, 3);
        add_point(2, 5);
        add_point(3, 7);
        add_point(4, 9);

        // let everything drain before the random part
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_fits != 0)
            @(posedge clk);

        // random runs of points with occasional clears
        for (int i = 0; i < 730; i++)
        begin
            if (i % 150 == 100)
                calm = ~calm;
            kind = $urandom_range(0, 99);
            if (kind < 4)
            begin
                send_item(CMD_CLEAR, 16'($urandom), 16'($urandom));
                base_x = $urandom_range(0, 65535) - 32768;
                base_y = $urandom_range(0, 65535) - 32768;
            end
            else if (kind < 70)
                send_item(CMD_ADD, 16'($urandom), 16'($urandom));
            else if (kind < 85)
                add_point(base_x + $urandom_range(0, 3), base_y + $urandom_range(0, 6) - 3);
            else if (kind < 92)
                add_point(base_x, $urandom_range(0, 65535) - 32768);
            else
                add_point($urandom_range(0, 65535) - 32768, base_y);
            if (i == 400)
            begin
                // hold off until every result is back
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_fits != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_fits != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d points and %0d clears with random gaps and stalls",
                 adds, clears);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/rlr_pkg.sv
rtl/core/rlr_mac.sv
rtl/core/rlr_div.sv
rtl/core/rlr_sqrt.sv
rtl/core/running_linear_regression_core.sv
verif/line_fit_checker.sv
verif/testbench.sv
